// ----- src/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// Spectral template classifier package
// Holds the widths, the pipeline depths and the normalized class templates.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int BAND_COUNT          = 4;
    localparam int CLASS_COUNT         = 5;
    localparam int RATIO_FRACTION_BITS = 16;

    localparam int STRENGTH_W  = 32;
    localparam int RATIO_W     = RATIO_FRACTION_BITS + 1;
    localparam int REM_W       = STRENGTH_W + 1;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_STAGES  = (RATIO_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int SQ_W        = 2 * RATIO_W;
    localparam int SUM_W       = SQ_W + $clog2(BAND_COUNT);
    localparam int ERR_W       = 19;
    localparam int CLASS_W     = 3;

    typedef logic [STRENGTH_W-1:0] strength_t;
    typedef logic [RATIO_W-1:0]    ratio_t;
    typedef logic [ERR_W-1:0]      err_t;
    typedef logic [CLASS_W-1:0]    class_t;

    typedef struct packed {
        logic [BAND_COUNT-1:0][REM_W-1:0] rem;
        logic [BAND_COUNT-1:0][RATIO_W-1:0] quot;
        strength_t peak;
        logic zero;
    } div_word_t;

    // Templates already divided by their own largest entry, unsigned Q1.16.
    localparam ratio_t TMPL_RATIO [CLASS_COUNT][BAND_COUNT] = '{
        '{17'd65536, 17'd49152, 17'd19660, 17'd6553},
        '{17'd65536, 17'd54613, 17'd43690, 17'd32768},
        '{17'd50412, 17'd65536, 17'd40329, 17'd20164},
        '{17'd65536, 17'd65536, 17'd49152, 17'd49152},
        '{17'd49152, 17'd65536, 17'd49152, 17'd49152}
    };

endpackage

// ----- src/stc_divider.sv -----
// ----------------------------------------------------------------------------
// Ratio divider
// Finds the peak strength and divides every band by it, two quotient bits
// per pipeline stage.
// ----------------------------------------------------------------------------
module stc_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [stc_pkg::BAND_COUNT-1:0][stc_pkg::STRENGTH_W-1:0] strength,
    output logic                                 out_valid,
    output stc_pkg::div_word_t                   out_word
);
    import stc_pkg::*;

    div_word_t pipe_reg [DIV_STAGES+1];
    logic      valid_reg [DIV_STAGES+1];
    div_word_t load_next;

    always_comb
    begin
        strength_t pk;
        pk = '0;
        for (int b = 0; b < BAND_COUNT; b++)
        begin
            if (strength[b] > pk)
            begin
                pk = strength[b];
            end
        end
        load_next.peak = pk;
        load_next.zero = (pk == '0);
        for (int b = 0; b < BAND_COUNT; b++)
        begin
            load_next.rem[b]  = {1'b0, strength[b]};
            load_next.quot[b] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= load_next;
        end
    end

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        div_word_t stage_next;

        always_comb
        begin
            logic qbit;
            stage_next = pipe_reg[j];
            for (int t = 0; t < DIV_STEPS; t++)
            begin
                if (j * DIV_STEPS + t < RATIO_W)
                begin
                    for (int b = 0; b < BAND_COUNT; b++)
                    begin
                        qbit = (stage_next.rem[b] >= {1'b0, stage_next.peak});
                        if (qbit)
                        begin
                            stage_next.rem[b] = stage_next.rem[b] - {1'b0, stage_next.peak};
                        end
                        stage_next.quot[b] = {stage_next.quot[b][RATIO_W-2:0], qbit};
                        stage_next.rem[b]  = {stage_next.rem[b][REM_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pipe_reg[j+1] <= stage_next;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES];
    assign out_word  = pipe_reg[DIV_STAGES];

endmodule

// ----- src/stc_match.sv -----
// ----------------------------------------------------------------------------
// Template matcher
// Squares the ratio differences, sums them per class and picks the class
// with the least error.
// ----------------------------------------------------------------------------
module stc_match (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [stc_pkg::BAND_COUNT-1:0][stc_pkg::RATIO_W-1:0] ratio,
    input  logic                  zero,
    output logic                  out_valid,
    output stc_pkg::class_t       class_index,
    output logic                  no_match,
    output stc_pkg::err_t         best_error
);
    import stc_pkg::*;

    logic [SQ_W-1:0] sq_reg [CLASS_COUNT][BAND_COUNT];
    logic [SQ_W-1:0] sq_next [CLASS_COUNT][BAND_COUNT];
    err_t            err_reg [CLASS_COUNT];
    err_t            err_next [CLASS_COUNT];
    logic            zero1_reg, zero2_reg;
    logic            v1_reg, v2_reg, v3_reg;
    class_t          cls_reg, cls_next;
    err_t            best_reg, best_next;
    logic            nm_reg;

    always_comb
    begin
        ratio_t d;
        for (int k = 0; k < CLASS_COUNT; k++)
        begin
            for (int b = 0; b < BAND_COUNT; b++)
            begin
                d = (ratio[b] > TMPL_RATIO[k][b]) ? ratio[b] - TMPL_RATIO[k][b]
                                                   : TMPL_RATIO[k][b] - ratio[b];
                sq_next[k][b] = SQ_W'(d) * SQ_W'(d);
            end
        end
    end

    always_comb
    begin
        logic [SUM_W-1:0] sum;
        for (int k = 0; k < CLASS_COUNT; k++)
        begin
            sum = '0;
            for (int b = 0; b < BAND_COUNT; b++)
            begin
                sum = sum + SUM_W'(sq_reg[k][b]);
            end
            err_next[k] = sum[RATIO_FRACTION_BITS +: ERR_W];
        end
    end

    always_comb
    begin
        best_next = err_reg[0];
        cls_next  = '0;
        for (int k = 1; k < CLASS_COUNT; k++)
        begin
            if (err_reg[k] < best_next)
            begin
                best_next = err_reg[k];
                cls_next  = CLASS_W'(k);
            end
        end
        if (zero2_reg)
        begin
            best_next = '0;
            cls_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg    <= sq_next;
            zero1_reg <= zero;
            err_reg   <= err_next;
            zero2_reg <= zero1_reg;
            cls_reg   <= cls_next;
            best_reg  <= best_next;
            nm_reg    <= zero2_reg;
        end
    end

    assign out_valid   = v3_reg;
    assign class_index = cls_reg;
    assign no_match    = nm_reg;
    assign best_error  = best_reg;

endmodule

// ----- src/spectral_template_classifier_core.sv -----
// ----------------------------------------------------------------------------
// Spectral template classifier core
// Normalizes four band strengths by their peak and returns the nearest
// of five class templates with its squared error.
// ----------------------------------------------------------------------------
// Path: input register, divider stages, then square, sum and select registers.
// Throughput: one request per cycle; the whole pipeline advances together
// and holds when a finished result is not taken.
// Reset: rst_n clears every valid bit asynchronously; no result is pending.
module spectral_template_classifier_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  stc_pkg::strength_t        band_strength_0,
    input  stc_pkg::strength_t        band_strength_1,
    input  stc_pkg::strength_t        band_strength_2,
    input  stc_pkg::strength_t        band_strength_3,
    output logic                      out_valid,
    input  logic                      out_ready,
    output stc_pkg::class_t           class_index,
    output logic                      no_match,
    output stc_pkg::err_t             best_error
);
    import stc_pkg::*;

    logic                                en;
    logic [BAND_COUNT-1:0][STRENGTH_W-1:0] strength;
    logic [BAND_COUNT-1:0][RATIO_W-1:0]    ratio;
    logic                                div_valid;
    div_word_t                           div_word;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign strength[0] = band_strength_0;
    assign strength[1] = band_strength_1;
    assign strength[2] = band_strength_2;
    assign strength[3] = band_strength_3;

    stc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .strength  (strength),
        .out_valid (div_valid),
        .out_word  (div_word)
    );

    assign ratio = div_word.quot;

    stc_match u_match (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (div_valid),
        .ratio       (ratio),
        .zero        (div_word.zero),
        .out_valid   (out_valid),
        .class_index (class_index),
        .no_match    (no_match),
        .best_error  (best_error)
    );

endmodule

// ----- src/stc_checker.sv -----
// ----------------------------------------------------------------------------
// Spectral template classifier checker
// Watches the ports of the core and flags results that cannot be right.
// ----------------------------------------------------------------------------
module stc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  stc_pkg::class_t    class_index,
    input  logic               no_match,
    input  stc_pkg::err_t      best_error
);
    import stc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(class_index)
                                    && $stable(best_error) && $stable(no_match))
        else $error("Result changed while stalled.");

    a_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_match |-> class_index == '0 && best_error == '0)
        else $error("No-match result carries a class or an error.");

    a_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> class_index < CLASS_W'(CLASS_COUNT))
        else $error("Class index out of range.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("Request refused with an empty output.");

endmodule

bind spectral_template_classifier_core stc_checker u_stc_checker (.*);

// ----- tb/spectral_template_classifier_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral template classifier core testbench
// Sends band strength requests under random idling on both sides and checks
// every result against a built-in predictor of the nearest-template match.
// A directed table covers zero input, extremes and equal bands before random traffic.
// ----------------------------------------------------------------------------
module spectral_template_classifier_core_test;

    import stc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_COUNT = 1880;

    typedef struct packed {
        class_t cls;
        logic   nomatch;
        err_t   err;
    } verdict_t;

    typedef struct {
        strength_t s [BAND_COUNT];
        logic      known;
        verdict_t  v;
    } request_row_t;

    localparam logic [31:0] TEMPLATE_RAW [5][4] = '{
        '{32'd200, 32'd150, 32'd60, 32'd20},
        '{32'd120, 32'd100, 32'd80, 32'd60},
        '{32'd100, 32'd130, 32'd80, 32'd40},
        '{32'd80, 32'd80, 32'd60, 32'd60},
        '{32'd30, 32'd40, 32'd30, 32'd30}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    strength_t band_strength_0;
    strength_t band_strength_1;
    strength_t band_strength_2;
    strength_t band_strength_3;
    logic      out_valid;
    logic      out_ready;
    class_t    class_index;
    logic      no_match;
    err_t      best_error;

    verdict_t  pending_verdicts [$];
    int        errors;
    int        results_seen;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off_cycles;

    spectral_template_classifier_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .band_strength_0 (band_strength_0),
        .band_strength_1 (band_strength_1),
        .band_strength_2 (band_strength_2),
        .band_strength_3 (band_strength_3),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .class_index     (class_index),
        .no_match        (no_match),
        .best_error      (best_error)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic verdict_t classify_spectrum(input strength_t s [BAND_COUNT]);
        logic [63:0] peak;
        logic [63:0] tpeak;
        logic [63:0] ratio [BAND_COUNT];
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] sum;
        logic [63:0] err;
        logic [63:0] best;
        verdict_t    v;
        peak = '0;
        best = '0;
        v = '0;
        for (int b = 0; b < BAND_COUNT; b++)
        begin
            if (64'(s[b]) > peak)
            begin
                peak = 64'(s[b]);
            end
        end
        if (peak == '0)
        begin
            v.nomatch = 1'b1;
            return v;
        end
        for (int b = 0; b < BAND_COUNT; b++)
        begin
            ratio[b] = ({32'd0, s[b]} << RATIO_FRACTION_BITS) / peak;
        end
        for (int k = 0; k < CLASS_COUNT; k++)
        begin
            tpeak = '0;
            sum = '0;
            for (int b = 0; b < BAND_COUNT; b++)
            begin
                if (64'(TEMPLATE_RAW[k][b]) > tpeak)
                begin
                    tpeak = 64'(TEMPLATE_RAW[k][b]);
                end
            end
            for (int b = 0; b < BAND_COUNT; b++)
            begin
                t = ({32'd0, TEMPLATE_RAW[k][b]} << RATIO_FRACTION_BITS) / tpeak;
                d = (ratio[b] > t) ? ratio[b] - t : t - ratio[b];
                sum = sum + d * d;
            end
            err = sum >> RATIO_FRACTION_BITS;
            if (k == 0 || err < best)
            begin
                best = err;
                v.cls = class_t'(k);
            end
        end
        v.err = (best > 64'd524287) ? err_t'(19'h7FFFF) : err_t'(best);
        return v;
    endfunction

    function automatic strength_t random_strength(input int shape);
        strength_t x;
        case (shape)
            0: x = '0;
            1: x = '1;
            2: x = $urandom_range(0, 255);
            3: x = $urandom & ($urandom_range(0, 1) ? 32'h0000FFFF : 32'hFFFFFFFF);
            default: x = $urandom;
        endcase
        return x;
    endfunction

    task automatic send_request(input strength_t s [BAND_COUNT], input logic known,
                                input verdict_t v);
        verdict_t guess;
        while (($urandom % 100) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        guess = classify_spectrum(s);
        if (known && guess !== v)
        begin
            $display("%0t: table row disagrees, expected %h got %h", $time, v, guess);
            errors++;
        end
        in_valid        <= 1'b1;
        band_strength_0 <= s[0];
        band_strength_1 <= s[1];
        band_strength_2 <= s[2];
        band_strength_3 <= s[3];
        pending_verdicts.push_back(known ? v : guess);
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_random(input int count);
        strength_t s [BAND_COUNT];
        int        shape;
        for (int i = 0; i < count; i++)
        begin
            shape = $urandom_range(0, 5);
            for (int b = 0; b < BAND_COUNT; b++)
            begin
                s[b] = random_strength(shape == 5 ? $urandom_range(0, 4) : 4);
            end
            if (shape == 3)
            begin
                for (int b = 0; b < BAND_COUNT; b++)
                begin
                    s[b] = TEMPLATE_RAW[$urandom_range(0, 4)][b] * $urandom_range(1, 1000);
                end
            end
            send_request(s, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: result with nothing pending, actual cls=%0d nm=%0b err=%0d",
                         $time, class_index, no_match, best_error);
                errors++;
            end
            else
            begin
                verdict_t v;
                v = pending_verdicts.pop_front();
                if (class_index !== v.cls)
                begin
                    $display("%0t: class_index expected %0d actual %0d", $time, v.cls,
                             class_index);
                    errors++;
                end
                if (no_match !== v.nomatch)
                begin
                    $display("%0t: no_match expected %0b actual %0b", $time, v.nomatch,
                             no_match);
                    errors++;
                end
                if (best_error !== v.err)
                begin
                    $display("%0t: best_error expected %0d actual %0d", $time, v.err,
                             best_error);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom % 100) >= recv_idle_pct;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        request_row_t rows [$];
        request_row_t r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        band_strength_0 = '0;
        band_strength_1 = '0;
        band_strength_2 = '0;
        band_strength_3 = '0;
        errors = 0;
        results_seen = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 16;
        recv_idle_pct = 57;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All-zero input has a fixed answer; the rest come from the predictor.
        r.known = 1'b1;
        r.v = '{cls: 3'd0, nomatch: 1'b1, err: '0};
        r.s = '{32'd0, 32'd0, 32'd0, 32'd0};
        rows.push_back(r);
        r.known = 1'b0;
        r.s = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        rows.push_back(r);
        r.s = '{32'd1, 32'd0, 32'd0, 32'd0};
        rows.push_back(r);
        r.s = '{32'd0, 32'd0, 32'd0, 32'hFFFFFFFF};
        rows.push_back(r);
        r.s = '{32'hFFFFFFFF, 32'd1, 32'd0, 32'd1};
        rows.push_back(r);
        r.s = '{32'd0, 32'hFFFFFFFF, 32'd0, 32'd0};
        rows.push_back(r);
        r.s = '{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555};
        rows.push_back(r);
        r.s = '{32'd1, 32'd1, 32'd1, 32'd1};
        rows.push_back(r);
        for (int k = 0; k < 5; k++)
        begin
            r.s = '{TEMPLATE_RAW[k][0], TEMPLATE_RAW[k][1], TEMPLATE_RAW[k][2],
                    TEMPLATE_RAW[k][3]};
            rows.push_back(r);
            r.s = '{TEMPLATE_RAW[k][0] * 20000000, TEMPLATE_RAW[k][1] * 20000000,
                    TEMPLATE_RAW[k][2] * 20000000, TEMPLATE_RAW[k][3] * 20000000};
            rows.push_back(r);
        end
        foreach (rows[i])
        begin
            send_request(rows[i].s, rows[i].known, rows[i].v);
        end

        run_random(RANDOM_COUNT / 3);
        in_valid <= 1'b0;

        // The sender waits here until every pending result has come back.
        wait (pending_verdicts.size() == 0);
        send_idle_pct = 57;
        recv_idle_pct = 16;
        hold_off_cycles = 300;
        run_random(RANDOM_COUNT / 3);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_COUNT - 2 * (RANDOM_COUNT / 3));
        in_valid <= 1'b0;

        wait (pending_verdicts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d results: zero input, extremes, scaled templates and random spectra.",
                 results_seen);
        $display("Idling ran on both sides, plus a long output stall and a full drain.");
        if (errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
